FILE: src/fpr_pkg.sv
// Shared types and constants for the framed packet receiver.
`default_nettype none

package fpr_pkg;

    // Frame marker bytes
    localparam logic [7:0] START_BYTE = 8'h06;
    localparam logic [7:0] SYNC_BYTE  = 8'h85;

    // Configuration register indexes
    localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
    localparam logic [2:0] REG_SLOT0_SIZE = 3'd1;
    localparam int         NUM_SIZE_REGS  = 4;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Receiver phase
    typedef enum logic [3:0] {
        ST_HUNT,
        ST_SYNC,
        ST_LEN,
        ST_IDX,
        ST_DATA,
        ST_CHECK,
        ST_ALIGN,
        ST_DRAIN,
        ST_ERR
    } t_phase;

endpackage

`default_nettype wire

FILE: src/fpr_cell.sv
// One byte cell of the payload shift chain.
`default_nettype none

module fpr_cell (
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_byte
);

    logic [7:0] r_byte;

    // Take the neighbor's byte whenever the chain moves
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

FILE: src/framed_packet_receiver.sv
// Framed packet receiver: top level with header FSM, checksum and payload cell chain.
// Accepts one received byte per cycle while hunting for a frame, reading its header,
// payload and check byte. A good check byte starts a commit: the payload sits in a
// chain of MAX_LEN byte cells fed from the top, so it first moves down until its
// first byte sits in cell 0, then one result per output transfer is read from cell
// 0 while the chain shifts, L results in all (L = frame length). A bad check byte
// gives one error result. Input is stalled after the check byte until the last
// result is taken. No clearing pass is needed after reset.
`default_nettype none

module framed_packet_receiver #(
    parameter int MAX_SLOTS = 4,
    parameter int MAX_LEN   = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [5:0] i_cfg_data,
    // received bytes
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    input  wire logic [7:0] i_rx_byte,
    // results
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic      [1:0] o_slot,
    output logic      [4:0] o_offset,
    output logic      [7:0] o_data,
    output logic            o_status,
    output logic            o_last
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // Configuration registers
    logic [2:0] r_slot_count;
    logic [5:0] r_slot_size [MAX_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                r_slot_size[s] <= 6'd1;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == fpr_pkg::REG_SLOT_COUNT) begin
                r_slot_count <= i_cfg_data[2:0];
            end
            for (int s = 0; s < MAX_SLOTS; s++) begin
                if (s < fpr_pkg::NUM_SIZE_REGS &&
                    i_cfg_index == fpr_pkg::REG_SLOT0_SIZE + 3'(s)) begin
                    r_slot_size[s] <= i_cfg_data;
                end
            end
        end
    end

    // Control state
    fpr_pkg::t_phase r_state, n_state;
    logic [7:0]      r_len,   n_len;
    logic [1:0]      r_slot,  n_slot;
    logic [CW-1:0]   r_cnt,   n_cnt;
    logic [7:0]      r_chk,   n_chk;

    logic       w_in_xfer;
    logic       w_out_xfer;
    logic       w_shift;
    logic [7:0] w_tail;
    logic       w_drop;
    logic       w_last;
    logic [5:0] w_size;
    logic [7:0] w_chain [MAX_LEN+1];

    assign w_in_xfer  = i_rx_valid && o_rx_ready;
    assign w_out_xfer = o_valid && i_ready;

    // Header acceptance: slot in range, length nonzero, within bound, matching slot size
    always_comb begin
        w_size = '0;
        if (i_rx_byte < 8'(MAX_SLOTS)) begin
            w_size = r_slot_size[i_rx_byte[SW-1:0]];
        end
        w_drop = (i_rx_byte >= {5'd0, r_slot_count}) || (i_rx_byte >= 8'(MAX_SLOTS)) ||
                 (r_len == 8'd0) || (r_len > 8'(MAX_LEN)) || (r_len != {2'b00, w_size});
    end

    assign w_last = ((9'(r_cnt) + 9'd1) == {1'b0, r_len});

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_slot  = r_slot;
        n_cnt   = r_cnt;
        n_chk   = r_chk;
        w_shift = 1'b0;
        unique case (r_state)
            fpr_pkg::ST_HUNT: begin
                if (w_in_xfer && i_rx_byte == fpr_pkg::START_BYTE) begin
                    n_state = fpr_pkg::ST_SYNC;
                end
            end
            fpr_pkg::ST_SYNC: begin
                if (w_in_xfer) begin
                    if (i_rx_byte == fpr_pkg::SYNC_BYTE) begin
                        n_state = fpr_pkg::ST_LEN;
                    end else begin
                        n_state = fpr_pkg::ST_HUNT;
                        n_cnt   = '0;
                    end
                end
            end
            fpr_pkg::ST_LEN: begin
                if (w_in_xfer) begin
                    n_len   = i_rx_byte;
                    n_state = fpr_pkg::ST_IDX;
                end
            end
            fpr_pkg::ST_IDX: begin
                if (w_in_xfer) begin
                    n_cnt = '0;
                    if (w_drop) begin
                        n_state = fpr_pkg::ST_HUNT;
                    end else begin
                        n_slot  = i_rx_byte[1:0];
                        n_chk   = r_len;
                        n_state = fpr_pkg::ST_DATA;
                    end
                end
            end
            fpr_pkg::ST_DATA: begin
                if (w_in_xfer) begin
                    w_shift = 1'b1;
                    n_chk   = r_chk ^ i_rx_byte;
                    n_cnt   = r_cnt + CW'(1);
                    if ((9'(r_cnt) + 9'd1) >= {1'b0, r_len}) begin
                        n_state = fpr_pkg::ST_CHECK;
                    end
                end
            end
            fpr_pkg::ST_CHECK: begin
                if (w_in_xfer) begin
                    if (i_rx_byte == r_chk) begin
                        if (r_cnt == CW'(MAX_LEN)) begin
                            n_state = fpr_pkg::ST_DRAIN;
                            n_cnt   = '0;
                        end else begin
                            n_state = fpr_pkg::ST_ALIGN;
                        end
                    end else begin
                        n_state = fpr_pkg::ST_ERR;
                        n_cnt   = '0;
                    end
                end
            end
            fpr_pkg::ST_ALIGN: begin
                // move the payload down until its first byte sits in cell 0
                w_shift = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(MAX_LEN - 1)) begin
                    n_state = fpr_pkg::ST_DRAIN;
                    n_cnt   = '0;
                end
            end
            fpr_pkg::ST_DRAIN: begin
                if (w_out_xfer) begin
                    if (w_last) begin
                        n_state = fpr_pkg::ST_HUNT;
                        n_cnt   = '0;
                    end else begin
                        w_shift = 1'b1;
                        n_cnt   = r_cnt + CW'(1);
                    end
                end
            end
            fpr_pkg::ST_ERR: begin
                if (w_out_xfer) begin
                    n_state = fpr_pkg::ST_HUNT;
                end
            end
            default: begin
                n_state = fpr_pkg::ST_HUNT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpr_pkg::ST_HUNT;
            r_len   <= '0;
            r_slot  <= '0;
            r_cnt   <= '0;
            r_chk   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_slot  <= n_slot;
            r_cnt   <= n_cnt;
            r_chk   <= n_chk;
        end
    end

    // Payload cell chain: fed at the top, read at cell 0
    assign w_tail = (r_state == fpr_pkg::ST_DATA) ? i_rx_byte : 8'd0;
    assign w_chain[MAX_LEN] = w_tail;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        fpr_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_byte  (w_chain[g+1]),
            .o_byte  (w_chain[g])
        );
    end

    // Outputs
    always_comb begin
        o_rx_ready = 1'b0;
        o_valid    = 1'b0;
        o_slot     = r_slot;
        o_offset   = 5'(r_cnt);
        o_data     = w_chain[0];
        o_status   = fpr_pkg::STATUS_OK;
        o_last     = w_last;
        unique case (r_state)
            fpr_pkg::ST_HUNT, fpr_pkg::ST_SYNC, fpr_pkg::ST_LEN,
            fpr_pkg::ST_IDX, fpr_pkg::ST_DATA, fpr_pkg::ST_CHECK: begin
                o_rx_ready = 1'b1;
            end
            fpr_pkg::ST_DRAIN: begin
                o_valid = 1'b1;
            end
            fpr_pkg::ST_ERR: begin
                o_valid  = 1'b1;
                o_offset = '0;
                o_data   = '0;
                o_status = fpr_pkg::STATUS_ERR;
                o_last   = 1'b1;
            end
            default: begin
                o_rx_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/fpr_checker.sv
// Port-level checker for the framed packet receiver and its bind.
`default_nettype none

module fpr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_rx_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_slot,
    input wire logic [4:0] o_offset,
    input wire logic [7:0] o_data,
    input wire logic       o_status,
    input wire logic       o_last
);

    // input is stalled while a result is pending
    a_stall_during_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_rx_ready)
        else $error("input ready while a result is pending");

    // an error result is a lone, zeroed, final result
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_last && o_data == 8'd0 && o_offset == 5'd0))
        else $error("malformed error result");

    // a run continues with the next offset right after a non-final transfer
    a_offset_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=>
            (o_valid && !o_status && o_offset == $past(o_offset) + 5'd1 &&
             o_slot == $past(o_slot)))
        else $error("result run broken");

    // the final transfer returns the block to receiving
    a_back_to_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (o_rx_ready && !o_valid))
        else $error("receiver not resumed after last result");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (.*);

`default_nettype wire

FILE: dv/tb_framed_packet_receiver.sv
// Self-checking testbench for the framed packet receiver: directed and random byte streams.
`default_nettype none

module tb_framed_packet_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS     = 4;
    localparam int MAX_LEN       = 32;
    localparam int SETTLE_CYCLES = 2 * MAX_LEN + 8;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PHASE_BYTES   = 36;

    typedef struct packed {
        logic [1:0] slot;
        logic [4:0] offset;
        logic [7:0] data;
        logic       status;
        logic       last;
    } t_frame_result;

    typedef logic [7:0] t_byte_q[$];

    // DUT connections, all inputs known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [5:0] i_cfg_data  = '0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = '0;
    logic       i_ready     = 1'b0;
    logic       o_rx_ready;
    logic       o_valid;
    logic [1:0] o_slot;
    logic [4:0] o_offset;
    logic [7:0] o_data;
    logic       o_status;
    logic       o_last;

    // Deframer shadow state and register copy
    fpr_pkg::t_phase rx_phase = fpr_pkg::ST_HUNT;
    logic [7:0] rx_len   = '0;
    logic [1:0] rx_slot  = '0;
    logic [5:0] rx_count = '0;
    logic [7:0] rx_check = '0;
    logic [7:0] rx_payload[MAX_LEN];
    logic [2:0] cfg_slot_count = '0;
    logic [5:0] cfg_slot_size[MAX_SLOTS] = '{default: 6'd1};

    t_frame_result frame_results_due[$];
    t_frame_result want;
    t_frame_result got;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int bytes_sent    = 0;
    int cycle_count   = 0;

    framed_packet_receiver #(
        .MAX_SLOTS (MAX_SLOTS),
        .MAX_LEN   (MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_slot      (o_slot),
        .o_offset    (o_offset),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side backpressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Slots usable by a frame: slot_count saturates at MAX_SLOTS
    function automatic int active_slots();
        return (cfg_slot_count < MAX_SLOTS) ? int'(cfg_slot_count) : MAX_SLOTS;
    endfunction

    function automatic void model_reg_write(input logic [2:0] idx, input logic [5:0] val);
        if (idx == fpr_pkg::REG_SLOT_COUNT) begin
            cfg_slot_count = val[2:0];
        end else if (idx >= fpr_pkg::REG_SLOT0_SIZE &&
                     idx < fpr_pkg::REG_SLOT0_SIZE + fpr_pkg::NUM_SIZE_REGS) begin
            cfg_slot_size[idx - fpr_pkg::REG_SLOT0_SIZE] = val;
        end
    endfunction

    function automatic void back_to_hunt();
        rx_phase = fpr_pkg::ST_HUNT;
        rx_count = '0;
    endfunction

    // Advance the deframer by one byte; queue whatever results it commits
    function automatic void deframe_byte(input logic [7:0] b);
        case (rx_phase)
            fpr_pkg::ST_HUNT: begin
                if (b == fpr_pkg::START_BYTE) rx_phase = fpr_pkg::ST_SYNC;
            end
            fpr_pkg::ST_SYNC: begin
                if (b == fpr_pkg::SYNC_BYTE) rx_phase = fpr_pkg::ST_LEN;
                else back_to_hunt();
            end
            fpr_pkg::ST_LEN: begin
                rx_len   = b;
                rx_phase = fpr_pkg::ST_IDX;
            end
            fpr_pkg::ST_IDX: begin
                if (b >= active_slots() || rx_len == 0 || rx_len > MAX_LEN ||
                    rx_len != {2'b00, cfg_slot_size[b[1:0]]}) begin
                    back_to_hunt();
                end else begin
                    rx_slot  = b[1:0];
                    rx_count = '0;
                    rx_check = rx_len;
                    rx_phase = fpr_pkg::ST_DATA;
                end
            end
            fpr_pkg::ST_DATA: begin
                rx_payload[rx_count[4:0]] = b;
                rx_check = rx_check ^ b;
                rx_count = rx_count + 6'd1;
                if (rx_count >= rx_len) rx_phase = fpr_pkg::ST_CHECK;
            end
            fpr_pkg::ST_CHECK: begin
                if (b == rx_check) begin
                    for (int i = 0; i < rx_len; i++) begin
                        frame_results_due.push_back('{rx_slot, 5'(i), rx_payload[i],
                                                      fpr_pkg::STATUS_OK,
                                                      (i + 1 == rx_len)});
                    end
                end else begin
                    frame_results_due.push_back('{rx_slot, 5'd0, 8'd0,
                                                  fpr_pkg::STATUS_ERR, 1'b1});
                end
                back_to_hunt();
            end
            default: back_to_hunt();
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Compare each result transfer with the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_slot, o_offset, o_data, o_status, o_last};
            if (frame_results_due.size() == 0) begin
                $error("unexpected result: slot %0d offset %0d data %0h status %0b",
                       o_slot, o_offset, o_data, o_status);
                fail_count++;
            end else begin
                want = frame_results_due.pop_front();
                check_field("slot",   8'(want.slot),   8'(got.slot));
                check_field("offset", 8'(want.offset), 8'(got.offset));
                check_field("data",   want.data,       got.data);
                check_field("status", 8'(want.status), 8'(got.status));
                check_field("last",   8'(want.last),   8'(got.last));
            end
        end
    end

    // One byte transfer; valid only drops when an idle gap is taken
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic send_seq(input t_byte_q seq);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic send_frame(input int slot, input logic [7:0] len, input bit corrupt);
        logic [7:0] chk;
        logic [7:0] b;
        send_byte(fpr_pkg::START_BYTE);
        send_byte(fpr_pkg::SYNC_BYTE);
        send_byte(len);
        send_byte(8'(slot));
        chk = len;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            chk ^= b;
            send_byte(b);
        end
        if (corrupt) chk ^= 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Hold off until every committed result is out and the block has gone quiet
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [5:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        model_reg_write(idx, val);
    endtask

    task automatic program_regs(input logic [2:0] count, input logic [5:0] s0,
                                input logic [5:0] s1, input logic [5:0] s2,
                                input logic [5:0] s3, input bit touch_unused);
        logic [5:0] sizes[fpr_pkg::NUM_SIZE_REGS];
        sizes = '{s0, s1, s2, s3};
        write_reg(fpr_pkg::REG_SLOT_COUNT, {3'b000, count});
        for (int k = 0; k < fpr_pkg::NUM_SIZE_REGS; k++) begin
            write_reg(fpr_pkg::REG_SLOT0_SIZE + 3'(k), sizes[k]);
        end
        // indexes past the size registers must be ignored
        if (touch_unused) begin
            for (int r = fpr_pkg::REG_SLOT0_SIZE + fpr_pkg::NUM_SIZE_REGS; r < 8; r++) begin
                write_reg(3'(r), '1);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // One random unit: mostly good frames, some noise and broken frames
    task automatic send_random_unit();
        int pick;
        int sel;
        int usable[$];
        logic [7:0] len;
        pick = $urandom_range(99);
        for (int s = 0; s < active_slots(); s++) begin
            if (cfg_slot_size[s] != 0 && cfg_slot_size[s] <= MAX_LEN) usable.push_back(s);
        end
        if (usable.size() > 0) begin
            sel = usable[$urandom_range(usable.size() - 1)];
            // keep long frames rare
            if (cfg_slot_size[sel] > 8 && $urandom_range(3) != 0)
                sel = usable[$urandom_range(usable.size() - 1)];
        end
        if (pick < 70 && usable.size() > 0) begin
            send_frame(sel, 8'(cfg_slot_size[sel]), $urandom_range(99) < 15);
        end else if (pick < 80) begin
            send_byte(8'($urandom_range(255)));
        end else if (pick < 87) begin
            send_byte(fpr_pkg::START_BYTE);
            send_byte(8'($urandom_range(255)));
        end else if (pick < 94 || usable.size() == 0) begin
            // header with an odd length or index
            case ($urandom_range(3))
                0: len = 8'd0;
                1: len = 8'd63;
                2: len = 8'($urandom_range(255));
                default: len = 8'(cfg_slot_size[$urandom_range(MAX_SLOTS - 1)] + 1);
            endcase
            send_byte(fpr_pkg::START_BYTE);
            send_byte(fpr_pkg::SYNC_BYTE);
            send_byte(len);
            send_byte(($urandom_range(1) != 0) ? 8'($urandom_range(MAX_SLOTS))
                                               : 8'($urandom_range(255)));
        end else begin
            // truncated frame: following bytes land in its payload
            send_byte(fpr_pkg::START_BYTE);
            send_byte(fpr_pkg::SYNC_BYTE);
            send_byte(8'(cfg_slot_size[sel]));
            send_byte(8'(sel));
            repeat ($urandom_range(cfg_slot_size[sel] - 1)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // Reset register values: no slots, then one slot of default size
    task automatic test_reset_values();
        t_byte_q seq;
        send_idle_pct = 24;
        recv_idle_pct = 72;
        seq = {fpr_pkg::START_BYTE, fpr_pkg::SYNC_BYTE, 8'h01, 8'h00, 8'hAA, 8'hAB};
        send_seq(seq);
        wait_drained();
        write_reg(fpr_pkg::REG_SLOT_COUNT, 6'd1);
        i_cfg_we <= 1'b0;
        seq = {fpr_pkg::START_BYTE, fpr_pkg::SYNC_BYTE, 8'h01, 8'h00, 8'hFF, 8'hFE};
        send_seq(seq);
    endtask

    // Directed frame cases on a full slot table
    task automatic test_directed_frames();
        t_byte_q seq;
        wait_drained();
        program_regs(3'd4, 6'd1, 6'd32, 6'd3, 6'd2, 1'b1);
        // repeated start byte restarts the hunt, then a one byte frame of zero
        seq = {fpr_pkg::START_BYTE, fpr_pkg::START_BYTE, fpr_pkg::START_BYTE,
               fpr_pkg::SYNC_BYTE, 8'h01, 8'h00, 8'h00, 8'h01};
        send_seq(seq);
        // bad check byte on the top slot
        seq = {fpr_pkg::START_BYTE, fpr_pkg::SYNC_BYTE, 8'h02, 8'h03, 8'hFF, 8'h80, 8'h00};
        send_seq(seq);
        // slot out of range, length mismatch, zero length, oversize length
        seq = {fpr_pkg::START_BYTE, fpr_pkg::SYNC_BYTE, 8'h01, 8'h04,
               fpr_pkg::START_BYTE, fpr_pkg::SYNC_BYTE, 8'h05, 8'h01,
               fpr_pkg::START_BYTE, fpr_pkg::SYNC_BYTE, 8'h00, 8'h00,
               fpr_pkg::START_BYTE, fpr_pkg::SYNC_BYTE, 8'hFF, 8'h00};
        send_seq(seq);
    endtask

    task automatic test_random_frames(input int snd_pct, input int rcv_pct,
                                      input logic [2:0] count, input logic [5:0] s0,
                                      input logic [5:0] s1, input logic [5:0] s2,
                                      input logic [5:0] s3, input bit touch_unused);
        int start_count;
        wait_drained();
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        program_regs(count, s0, s1, s2, s3, touch_unused);
        start_count = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES) send_random_unit();
    endtask

    // Run watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** framed_packet_receiver: FAILED **");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed_frames();
        test_random_frames(24, 72, 3'd4, 6'($urandom_range(1, 6)), 6'd32,
                           6'($urandom_range(1, 6)), 6'($urandom_range(1, 6)), 1'b0);
        // slot_count above the table size, a zero size and an oversize entry
        test_random_frames(72, 24, 3'd7, 6'd0, 6'($urandom_range(1, 6)), 6'd63,
                           6'($urandom_range(2, 5)), 1'b1);
        test_random_frames(0, 0, 3'd2, 6'($urandom_range(1, 6)), 6'($urandom_range(1, 6)),
                           6'd4, 6'd4, 1'b0);
        wait_drained();
        if (fail_count == 0) begin
            $display("** framed_packet_receiver: PASSED **");
        end else begin
            $display("** framed_packet_receiver: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
